// ----- rtl/core/s2c_pkg.sv -----
// ============================================================================
// s2c_pkg
// Shared widths, constants, types and the rounding and saturation helpers
// of the spherical-to-Cartesian converter.
// ============================================================================
package s2c_pkg;

    // Field widths
    localparam int LAT_W = 18;
    localparam int LON_W = 19;
    localparam int RAD_W = 23;
    localparam int OUT_W = 24;

    // Angle format of the input words and internal angle format (Q30 radians)
    localparam int ANGLE_FRAC_BITS     = 16;
    localparam int CORDIC_STAGES_DEF   = 18;
    localparam int CORDIC_STAGES_MAX   = 32;
    localparam int Q_BITS              = 30;
    localparam int ANG_SHIFT           = Q_BITS - ANGLE_FRAC_BITS;

    // Scaled angle before range reduction, with one guard bit for the wrap
    localparam int ANG_W  = LON_W + ANG_SHIFT + 1;
    // CORDIC residual angle, |z| stays below pi/2 + atan(1)
    localparam int ZW     = Q_BITS + 3;
    // CORDIC x / y and sine / cosine in Q30
    localparam int CS_W   = Q_BITS + 2;
    // Products
    localparam int PROD_W = 2 * CS_W;
    localparam int MUL_W  = CS_W + RAD_W + 1;

    localparam logic signed [ANG_W-1:0] PI_Q30      = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = ANG_W'(64'sd6746518852);
    localparam logic signed [CS_W-1:0]  GAIN_Q30    = CS_W'(64'sd652032874);

    localparam logic [RAD_W-1:0]         RADIUS_RESET = RAD_W'(6378137);
    localparam logic signed [PROD_W-1:0] OUT_MAX      = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] ROUND_HALF   = PROD_W'(64'sd1) <<< (Q_BITS - 1);

    // atan(2^-i) in Q30, floored
    localparam logic [31:0] ATAN_Q30 [CORDIC_STAGES_MAX] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    typedef logic signed [CS_W-1:0]  t_cs;
    typedef logic signed [ANG_W-1:0] t_angle;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_coords;

    // Shift right by Q_BITS, round to nearest with ties away from zero
    function automatic logic signed [PROD_W-1:0] round_q30(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] adj;
        adj = v[PROD_W-1] ? (ROUND_HALF - PROD_W'(64'sd1)) : ROUND_HALF;
        round_q30 = (v + adj) >>> Q_BITS;
    endfunction

    // Clamp to the symmetric output range
    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [PROD_W-1:0] v
    );
        if (v > OUT_MAX) begin
            sat_out = OUT_W'(OUT_MAX);
        end else if (v < -OUT_MAX) begin
            sat_out = OUT_W'(-OUT_MAX);
        end else begin
            sat_out = v[OUT_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/s2c_sincos.sv -----
// ============================================================================
// s2c_sincos
// Pipelined sine / cosine of one Q30 angle: wrap into [-pi, pi), fold into
// [-pi/2, pi/2], one CORDIC rotation per stage, then fix the cosine sign.
// ============================================================================
module s2c_sincos #(
    parameter int STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  s2c_pkg::t_angle  i_angle,
    output logic             o_vld,
    output s2c_pkg::t_cs     o_cos,
    output s2c_pkg::t_cs     o_sin
);
    import s2c_pkg::*;

    logic                    r_vld_wrap;
    logic signed [ANG_W-1:0] r_wrap;
    logic signed [ANG_W-1:0] n_wrap;
    logic                    r_vld_fold;
    logic signed [ZW-1:0]    r_z0;
    logic                    r_flip0;
    logic signed [ZW-1:0]    n_z0;
    logic                    n_flip0;

    logic                    r_v [STAGES];
    logic signed [CS_W-1:0]  r_x [STAGES];
    logic signed [CS_W-1:0]  r_y [STAGES];
    logic signed [ZW-1:0]    r_z [STAGES];
    logic                    r_f [STAGES];

    logic                    r_vld_out;
    logic signed [CS_W-1:0]  r_cos;
    logic signed [CS_W-1:0]  r_sin;

    // Wrap once by 2*pi; the scaled input never reaches 2*pi in magnitude
    always_comb begin
        if (i_angle >= PI_Q30) begin
            n_wrap = i_angle - TWO_PI_Q30;
        end else if (i_angle < -PI_Q30) begin
            n_wrap = i_angle + TWO_PI_Q30;
        end else begin
            n_wrap = i_angle;
        end
    end

    // Fold the outer half circle onto the inner one, negating the cosine
    always_comb begin
        logic signed [ANG_W-1:0] t_z;
        t_z     = r_wrap;
        n_flip0 = 1'b0;
        if (r_wrap > HALF_PI_Q30) begin
            t_z     = PI_Q30 - r_wrap;
            n_flip0 = 1'b1;
        end else if (r_wrap < -HALF_PI_Q30) begin
            t_z     = -PI_Q30 - r_wrap;
            n_flip0 = 1'b1;
        end
        n_z0 = t_z[ZW-1:0];
    end

    // Front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_wrap <= 1'b0;
            r_vld_fold <= 1'b0;
        end else if (i_en) begin
            r_vld_wrap <= i_vld;
            r_vld_fold <= r_vld_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wrap  <= n_wrap;
            r_z0    <= n_z0;
            r_flip0 <= n_flip0;
        end
    end

    // CORDIC rotation stages
    for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
        logic                   w_vi;
        logic signed [CS_W-1:0] w_xi;
        logic signed [CS_W-1:0] w_yi;
        logic signed [ZW-1:0]   w_zi;
        logic                   w_fi;
        logic signed [CS_W-1:0] n_x;
        logic signed [CS_W-1:0] n_y;
        logic signed [ZW-1:0]   n_z;
        logic signed [ZW-1:0]   w_atan;

        if (gi == 0) begin : g_first
            assign w_vi = r_vld_fold;
            assign w_xi = GAIN_Q30;
            assign w_yi = '0;
            assign w_zi = r_z0;
            assign w_fi = r_flip0;
        end else begin : g_next
            assign w_vi = r_v[gi-1];
            assign w_xi = r_x[gi-1];
            assign w_yi = r_y[gi-1];
            assign w_zi = r_z[gi-1];
            assign w_fi = r_f[gi-1];
        end

        assign w_atan = $signed({{(ZW-32){1'b0}}, ATAN_Q30[gi]});

        // Rotate toward zero residual angle
        always_comb begin
            if (!w_zi[ZW-1]) begin
                n_x = w_xi - (w_yi >>> gi);
                n_y = w_yi + (w_xi >>> gi);
                n_z = w_zi - w_atan;
            end else begin
                n_x = w_xi + (w_yi >>> gi);
                n_y = w_yi - (w_xi >>> gi);
                n_z = w_zi + w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_en) begin
                r_v[gi] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[gi] <= n_x;
                r_y[gi] <= n_y;
                r_z[gi] <= n_z;
                r_f[gi] <= w_fi;
            end
        end
    end

    // Apply the fold to the cosine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld_out <= r_v[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_f[STAGES-1] ? -r_x[STAGES-1] : r_x[STAGES-1];
            r_sin <= r_y[STAGES-1];
        end
    end

    assign o_vld = r_vld_out;
    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ----- rtl/core/s2c_scale.sv -----
// ============================================================================
// s2c_scale
// Forms cos(lat)cos(lon) and cos(lat)sin(lon), scales all three by the
// radius, then rounds to whole meters and saturates.
// ============================================================================
module s2c_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  s2c_pkg::t_cs                i_clat,
    input  s2c_pkg::t_cs                i_slat,
    input  s2c_pkg::t_cs                i_clon,
    input  s2c_pkg::t_cs                i_slon,
    input  logic [s2c_pkg::RAD_W-1:0]   i_radius,
    output logic                        o_vld,
    output s2c_pkg::t_coords            o_coords
);
    import s2c_pkg::*;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic signed [PROD_W-1:0] r_pxf;
    logic signed [PROD_W-1:0] r_pyf;
    logic signed [CS_W-1:0]   r_slat1;
    logic signed [CS_W-1:0]   r_px;
    logic signed [CS_W-1:0]   r_py;
    logic signed [CS_W-1:0]   r_slat2;
    logic signed [MUL_W-1:0]  r_mx;
    logic signed [MUL_W-1:0]  r_my;
    logic signed [MUL_W-1:0]  r_mz;

    logic signed [PROD_W-1:0] w_rpx;
    logic signed [PROD_W-1:0] w_rpy;
    logic signed [RAD_W:0]    w_rad;
    logic signed [PROD_W-1:0] w_rx;
    logic signed [PROD_W-1:0] w_ry;
    logic signed [PROD_W-1:0] w_rz;

    assign w_rpx = round_q30(r_pxf);
    assign w_rpy = round_q30(r_pyf);
    assign w_rad = $signed({1'b0, i_radius});

    // Valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Product, round to Q30, scale by radius
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxf   <= i_clat * i_clon;
            r_pyf   <= i_clat * i_slon;
            r_slat1 <= i_slat;
            r_px    <= w_rpx[CS_W-1:0];
            r_py    <= w_rpy[CS_W-1:0];
            r_slat2 <= r_slat1;
            r_mx    <= r_px * w_rad;
            r_my    <= r_py * w_rad;
            r_mz    <= r_slat2 * w_rad;
        end
    end

    // Round to meters and clamp
    assign w_rx = round_q30($signed({{(PROD_W-MUL_W){r_mx[MUL_W-1]}}, r_mx}));
    assign w_ry = round_q30($signed({{(PROD_W-MUL_W){r_my[MUL_W-1]}}, r_my}));
    assign w_rz = round_q30($signed({{(PROD_W-MUL_W){r_mz[MUL_W-1]}}, r_mz}));

    assign o_vld      = r_v3;
    assign o_coords.x = sat_out(w_rx);
    assign o_coords.y = sat_out(w_ry);
    assign o_coords.z = sat_out(w_rz);

endmodule

// ----- rtl/core/spherical_to_cartesian.sv -----
// ============================================================================
// spherical_to_cartesian: latitude / longitude to x, y, z on a sphere
// Throughput: one word per cycle while the skid entry is free, one CORDIC rotation per stage.
// A two-entry output register with skid keeps input open while a word waits.
// Reset clears all valid bits and loads sphere_radius with 6378137.
// ============================================================================
module spherical_to_cartesian #(
    parameter int CORDIC_STAGES = s2c_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [s2c_pkg::RAD_W-1:0]          i_sphere_radius,
    // Input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [s2c_pkg::LAT_W-1:0]   i_lat_angle,
    input  logic signed [s2c_pkg::LON_W-1:0]   i_lon_angle,
    // Output words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [s2c_pkg::OUT_W-1:0]   o_coord_x,
    output logic signed [s2c_pkg::OUT_W-1:0]   o_coord_y,
    output logic signed [s2c_pkg::OUT_W-1:0]   o_coord_z
);
    import s2c_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic             w_en;
    logic             w_in_vld;
    t_angle           w_lat_q30;
    t_angle           w_lon_q30;
    logic             w_lat_vld;
    logic             w_lon_vld;
    t_cs              w_clat;
    t_cs              w_slat;
    t_cs              w_clon;
    t_cs              w_slon;
    logic             w_res_vld;
    t_coords          w_res;

    logic             r_out_vld;
    t_coords          r_out;
    logic             r_skid_vld;
    t_coords          r_skid;

    // Radius register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_sphere_radius;
        end
    end

    // Pipeline advances while the skid entry is free
    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;
    assign w_in_vld   = i_in_valid;

    // Scale angles to Q30 radians
    assign w_lat_q30 = $signed({{(ANG_W-LAT_W-ANG_SHIFT){i_lat_angle[LAT_W-1]}},
                                i_lat_angle, {ANG_SHIFT{1'b0}}});
    assign w_lon_q30 = $signed({{(ANG_W-LON_W-ANG_SHIFT){i_lon_angle[LON_W-1]}},
                                i_lon_angle, {ANG_SHIFT{1'b0}}});

    s2c_sincos #(
        .STAGES (CORDIC_STAGES)
    ) u_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_in_vld),
        .i_angle (w_lat_q30),
        .o_vld   (w_lat_vld),
        .o_cos   (w_clat),
        .o_sin   (w_slat)
    );

    s2c_sincos #(
        .STAGES (CORDIC_STAGES)
    ) u_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_in_vld),
        .i_angle (w_lon_q30),
        .o_vld   (w_lon_vld),
        .o_cos   (w_clon),
        .o_sin   (w_slon)
    );

    s2c_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_lat_vld && w_lon_vld),
        .i_clat   (w_clat),
        .i_slat   (w_slat),
        .i_clon   (w_clon),
        .i_slon   (w_slon),
        .i_radius (r_radius),
        .o_vld    (w_res_vld),
        .o_coords (w_res)
    );

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_res_vld) begin
            if (!r_out_vld || i_out_ready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (w_res_vld) begin
            if (!r_out_vld || i_out_ready) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_coord_x   = r_out.x;
    assign o_coord_y   = r_out.y;
    assign o_coord_z   = r_out.z;

    // The skid entry only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid with empty output register");

    // Draining the skid entry leaves a word at the output
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_out_ready) |=> (r_out_vld && !r_skid_vld))
        else $error("skid drain lost a word");

    // Saturation never yields the most negative code
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coord_x != $signed({1'b1, {(OUT_W-1){1'b0}}}) &&
                         o_coord_y != $signed({1'b1, {(OUT_W-1){1'b0}}}) &&
                         o_coord_z != $signed({1'b1, {(OUT_W-1){1'b0}}})))
        else $error("output outside saturated range");

    // Radius changes only on a configuration write
    a_radius_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_radius))
        else $error("radius changed without a write");

endmodule
